// ===== hw/rtl/lifet_pkg.sv =====
// shared types and constants for the toroidal life grid block
// no dependencies; used by lifet_cmd_if, lifet_cfg, lifet_row_unit, the top level and the testbench
`default_nettype none

package lifet_pkg;

    // payload field widths
    localparam int MODE_W  = 2;
    localparam int COORD_W = 6;
    localparam int LOG2_W  = 3;

    // command modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_WIDTH_LOG2  = 1'b0;
    localparam logic REG_HEIGHT_LOG2 = 1'b1;
    localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd6;

    // life rule neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [LOG2_W-1:0] width_log2;
        logic [LOG2_W-1:0] height_log2;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lifet_cmd_if.sv =====
// command channel: valid/ready handshake carrying mode, column and row
// depends on lifet_pkg for field widths
`default_nettype none

interface lifet_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [lifet_pkg::MODE_W-1:0]  mode;
    logic [lifet_pkg::COORD_W-1:0] column;
    logic [lifet_pkg::COORD_W-1:0] row;

    modport source (output valid, output mode, output column, output row, input ready);
    modport sink   (input valid, input mode, input column, input row, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lifet_res_if.sv =====
// result channel: valid/ready handshake carrying the alive bit
// no package dependency
`default_nettype none

interface lifet_res_if;
    logic valid;
    logic ready;
    logic alive;

    modport source (output valid, output alive, input ready);
    modport sink   (input valid, input alive, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lifet_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lifet_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lifet_cfg.sv =====
// apb-style configuration registers for the grid size
// depends on lifet_pkg for the address map and cfg_t
`default_nettype none

module lifet_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lifet_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lifet_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lifet_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready,
    output lifet_pkg::cfg_t                          cfg
);

    lifet_pkg::cfg_t cfg_reg;
    lifet_pkg::cfg_t cfg_next;
    logic            wr_en;
    logic            reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                lifet_pkg::REG_WIDTH_LOG2:
                    cfg_next.width_log2 = pwdata[lifet_pkg::LOG2_W-1:0];
                lifet_pkg::REG_HEIGHT_LOG2:
                    cfg_next.height_log2 = pwdata[lifet_pkg::LOG2_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_log2  <= lifet_pkg::LOG2_RESET;
            cfg_reg.height_log2 <= lifet_pkg::LOG2_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lifet_pkg::REG_WIDTH_LOG2:
                prdata = {{(lifet_pkg::APB_DATA_W-lifet_pkg::LOG2_W){1'b0}},
                          cfg_reg.width_log2};
            lifet_pkg::REG_HEIGHT_LOG2:
                prdata = {{(lifet_pkg::APB_DATA_W-lifet_pkg::LOG2_W){1'b0}},
                          cfg_reg.height_log2};
            default:
                prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lifet_row_unit.sv =====
// next-generation unit for one full row, all columns in parallel
// depends on lifet_pkg for the rule counts
`default_nettype none

module lifet_row_unit #(
    parameter int MAX_WIDTH_LOG2 = 6
) (
    input  wire logic [(1<<MAX_WIDTH_LOG2)-1:0] up_row,
    input  wire logic [(1<<MAX_WIDTH_LOG2)-1:0] cur_row,
    input  wire logic [(1<<MAX_WIDTH_LOG2)-1:0] dn_row,
    input  wire logic [MAX_WIDTH_LOG2-1:0]      wmask,
    output logic      [(1<<MAX_WIDTH_LOG2)-1:0] next_row
);

    localparam int NCOL = 1 << MAX_WIDTH_LOG2;

    genvar c;
    generate
        for (c = 0; c < NCOL; c++)
        begin : g_col
            logic       up_l, up_r, cur_l, cur_r, dn_l, dn_r;
            logic [3:0] cnt;
            logic       in_area;

            // columns wrap at the active width
            if (c == 0)
            begin : g_first
                assign up_l  = up_row[wmask];
                assign cur_l = cur_row[wmask];
                assign dn_l  = dn_row[wmask];
            end
            else
            begin : g_mid_l
                assign up_l  = up_row[c-1];
                assign cur_l = cur_row[c-1];
                assign dn_l  = dn_row[c-1];
            end

            if (c == NCOL-1)
            begin : g_last
                assign up_r  = up_row[0];
                assign cur_r = cur_row[0];
                assign dn_r  = dn_row[0];
            end
            else
            begin : g_mid_r
                logic is_edge;
                assign is_edge = (MAX_WIDTH_LOG2'(c) == wmask);
                assign up_r  = is_edge ? up_row[0]  : up_row[c+1];
                assign cur_r = is_edge ? cur_row[0] : cur_row[c+1];
                assign dn_r  = is_edge ? dn_row[0]  : dn_row[c+1];
            end

            assign cnt = 4'(up_l) + 4'(up_row[c]) + 4'(up_r)
                       + 4'(cur_l) + 4'(cur_r)
                       + 4'(dn_l) + 4'(dn_row[c]) + 4'(dn_r);

            assign in_area = (MAX_WIDTH_LOG2'(c) <= wmask);

            assign next_row[c] = in_area &&
                ((cnt == lifet_pkg::BIRTH_COUNT) ||
                 ((cnt == lifet_pkg::SURVIVE_COUNT) && cur_row[c]));
        end
    endgenerate

endmodule

`default_nettype wire

// ===== hw/rtl/life_automaton_torus_grid.sv =====
// top level of the toroidal life grid: sequencer, row store and row unit
// depends on lifet_pkg, lifet_cmd_if, lifet_res_if, lifet_ram, lifet_cfg, lifet_row_unit
//
// usage:
//   cmd channel takes one beat per command (mode, column, row); res channel
//   returns exactly one beat per command, alive = cell state for a read, else 0.
//   the grid lives in a row memory, one row per word; a per-row valid flag
//   makes never-written and cleared rows read as dead.
//   steps from cmd beat to res valid:
//     clear          all row valid flags dropped, then the result is registered
//     set / read     one row read, then modified and written back for a set, or
//                    the cell bit picked for a read
//     generation     last row and row 0 read, then one row per cycle through the
//                    row unit, paced by the single memory read port
//   commands are taken one at a time; the result register lets one finished
//   beat wait while the next command is accepted and worked on.
//   if res stalls, the sequencer holds its finished result until the register
//   frees up.
//   reset: all cells dead, width_log2 = height_log2 = 6, channels empty.
//   size registers are to be written by the user over the apb port only while
//   no command is in flight; the block itself does not enforce this.
`default_nettype none

module life_automaton_torus_grid #(
    parameter int MAX_WIDTH_LOG2  = 6,
    parameter int MAX_HEIGHT_LOG2 = 6
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    lifet_cmd_if.sink                                cmd,
    lifet_res_if.source                              res,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lifet_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lifet_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lifet_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready
);

    localparam int CW   = MAX_WIDTH_LOG2;
    localparam int RW   = MAX_HEIGHT_LOG2;
    localparam int NCOL = 1 << MAX_WIDTH_LOG2;
    localparam int NROW = 1 << MAX_HEIGHT_LOG2;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RMW     = 6'b000010,
        S_GEN_A   = 6'b000100,
        S_GEN_B   = 6'b001000,
        S_GEN_ROW = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    lifet_pkg::cfg_t cfg;

    state_t                          state_reg, state_next;
    logic [lifet_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic [CW-1:0]                   col_reg, col_next;
    logic [RW-1:0]                   row_reg, row_next;
    logic [RW-1:0]                   cnt_reg, cnt_next;
    logic                            res_reg, res_next;
    logic [NCOL-1:0]                 up_reg, up_next;
    logic [NCOL-1:0]                 cur_reg, cur_next;
    logic [NCOL-1:0]                 first_reg, first_next;
    logic [NROW-1:0]                 valid_reg, valid_next;
    logic                            rvld_reg;
    logic                            out_valid_reg, out_valid_next;
    logic                            alive_reg, alive_next;

    logic [3:0]                      wl, hl;
    logic [CW:0]                     wfull;
    logic [RW:0]                     hfull;
    logic [CW-1:0]                   wmask;
    logic [RW-1:0]                   hmask;
    logic [CW-1:0]                   col_in;
    logic [RW-1:0]                   row_in;
    logic                            cmd_fire;

    logic                            ram_we;
    logic [RW-1:0]                   ram_waddr;
    logic [NCOL-1:0]                 ram_wdata;
    logic [RW-1:0]                   ram_raddr;
    logic [NCOL-1:0]                 ram_rdata;
    logic [NCOL-1:0]                 rd_row;
    logic [NCOL-1:0]                 dn_row;
    logic [NCOL-1:0]                 new_row;
    logic                            last_row;

    lifet_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // size saturates to 1..max
    always_comb
    begin
        if (cfg.width_log2 == '0)
            wl = 4'd1;
        else if ({1'b0, cfg.width_log2} > 4'(MAX_WIDTH_LOG2))
            wl = 4'(MAX_WIDTH_LOG2);
        else
            wl = {1'b0, cfg.width_log2};

        if (cfg.height_log2 == '0)
            hl = 4'd1;
        else if ({1'b0, cfg.height_log2} > 4'(MAX_HEIGHT_LOG2))
            hl = 4'(MAX_HEIGHT_LOG2);
        else
            hl = {1'b0, cfg.height_log2};
    end

    assign wfull = (CW+1)'(1) << wl;
    assign hfull = (RW+1)'(1) << hl;
    assign wmask = CW'(wfull - (CW+1)'(1));
    assign hmask = RW'(hfull - (RW+1)'(1));

    assign col_in   = CW'(cmd.column) & wmask;
    assign row_in   = RW'(cmd.row) & hmask;
    assign cmd_fire = cmd.valid && cmd.ready;

    assign rd_row   = rvld_reg ? ram_rdata : '0;
    assign last_row = (cnt_reg == hmask);
    // the last row wraps onto the saved original row 0
    assign dn_row   = last_row ? first_reg : rd_row;

    lifet_ram #(
        .WIDTH (NCOL),
        .DEPTH (NROW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lifet_row_unit #(
        .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2)
    ) u_row_unit (
        .up_row   (up_reg),
        .cur_row  (cur_reg),
        .dn_row   (dn_row),
        .wmask    (wmask),
        .next_row (new_row)
    );

    // read address: the row needed next, issued ahead since the ram read is registered
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
                ram_raddr = (cmd.mode == lifet_pkg::MODE_STEP) ? hmask : row_in;
            S_GEN_A:
                ram_raddr = '0;
            S_GEN_B:
                ram_raddr = RW'(1) & hmask;
            S_GEN_ROW:
                ram_raddr = (cnt_reg + RW'(2)) & hmask;
            default:
                ram_raddr = row_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        up_next        = up_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !res.ready;
        alive_next     = alive_reg;
        ram_we         = 1'b0;
        ram_waddr      = row_reg;
        ram_wdata      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    mode_next = cmd.mode;
                    col_next  = col_in;
                    row_next  = row_in;
                    res_next  = 1'b0;
                    unique case (cmd.mode)
                        lifet_pkg::MODE_CLEAR:
                        begin
                            valid_next = '0;
                            state_next = S_DONE;
                        end
                        lifet_pkg::MODE_STEP:
                            state_next = S_GEN_A;
                        default:
                            state_next = S_RMW;
                    endcase
                end
            end

            S_RMW:
            begin
                if (mode_reg == lifet_pkg::MODE_SET)
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = row_reg;
                    ram_wdata           = rd_row | (NCOL'(1) << col_reg);
                    valid_next[row_reg] = 1'b1;
                end
                else
                begin
                    res_next = rd_row[col_reg];
                end
                state_next = S_DONE;
            end

            S_GEN_A:
            begin
                up_next    = rd_row;
                state_next = S_GEN_B;
            end

            S_GEN_B:
            begin
                cur_next   = rd_row;
                first_next = rd_row;
                cnt_next   = '0;
                state_next = S_GEN_ROW;
            end

            S_GEN_ROW:
            begin
                ram_we              = 1'b1;
                ram_waddr           = cnt_reg;
                ram_wdata           = new_row;
                valid_next[cnt_reg] = 1'b1;
                up_next             = cur_reg;
                cur_next            = rd_row;
                cnt_next            = cnt_reg + RW'(1);
                if (last_row)
                begin
                    // rows outside the active height die
                    for (int i = 0; i < NROW; i++)
                    begin
                        valid_next[i] = (RW'(i) <= hmask);
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    alive_next     = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            rvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rvld_reg      <= valid_reg[ram_raddr];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        up_reg    <= up_next;
        cur_reg   <= cur_next;
        first_reg <= first_next;
        alive_reg <= alive_next;
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.alive = alive_reg;

endmodule

`default_nettype wire

// ===== test/life_automaton_torus_grid_test.sv =====
// self-checking testbench for the toroidal life grid: directed table, then random phases
// drives cmd and res through lifet_cmd_if / lifet_res_if and sizes through apb
// depends on lifet_pkg, the two channel interfaces and life_automaton_torus_grid
`timescale 1ns / 1ps

module life_automaton_torus_grid_test;

    localparam int GRID_LOG2_MAX = 6;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 34;

    typedef struct packed {
        logic [lifet_pkg::MODE_W-1:0]  mode;
        logic [lifet_pkg::COORD_W-1:0] column;
        logic [lifet_pkg::COORD_W-1:0] row;
        logic                          typed;
        logic                          alive;
    } grid_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [lifet_pkg::APB_ADDR_W-1:0] paddr;
    logic [lifet_pkg::APB_DATA_W-1:0] pwdata;
    logic [lifet_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    lifet_cmd_if cmd_ch();
    lifet_res_if res_ch();

    // shadow copy of the grid and the size registers
    logic [63:0]                  shadow_cells [64];
    logic [lifet_pkg::LOG2_W-1:0] width_sel;
    logic [lifet_pkg::LOG2_W-1:0] height_sel;

    logic        alive_queue [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;

    grid_cmd_t directed_rows [23] = '{
        '{lifet_pkg::MODE_READ,  6'd0,  6'd0,  1'b1, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd63, 6'd63, 1'b1, 1'b0},
        '{lifet_pkg::MODE_SET,   6'd63, 6'd63, 1'b1, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd63, 6'd63, 1'b1, 1'b1},
        '{lifet_pkg::MODE_READ,  6'd0,  6'd0,  1'b1, 1'b0},
        // blinker on row 0 that wraps across the column edge
        '{lifet_pkg::MODE_SET,   6'd0,  6'd0,  1'b0, 1'b0},
        '{lifet_pkg::MODE_SET,   6'd63, 6'd0,  1'b0, 1'b0},
        '{lifet_pkg::MODE_SET,   6'd1,  6'd0,  1'b0, 1'b0},
        '{lifet_pkg::MODE_STEP,  6'd0,  6'd0,  1'b0, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd0,  6'd63, 1'b0, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd0,  6'd1,  1'b0, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd63, 6'd0,  1'b0, 1'b0},
        '{lifet_pkg::MODE_STEP,  6'd17, 6'd44, 1'b0, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd63, 6'd0,  1'b0, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd1,  6'd0,  1'b0, 1'b0},
        '{lifet_pkg::MODE_CLEAR, 6'd63, 6'd63, 1'b0, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd0,  6'd0,  1'b1, 1'b0},
        '{lifet_pkg::MODE_SET,   6'd42, 6'd21, 1'b0, 1'b0},
        '{lifet_pkg::MODE_SET,   6'd21, 6'd42, 1'b0, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd42, 6'd21, 1'b1, 1'b1},
        '{lifet_pkg::MODE_READ,  6'd21, 6'd42, 1'b1, 1'b1},
        '{lifet_pkg::MODE_STEP,  6'd0,  6'd0,  1'b0, 1'b0},
        '{lifet_pkg::MODE_READ,  6'd42, 6'd21, 1'b0, 1'b0}
    };

    life_automaton_torus_grid #(
        .MAX_WIDTH_LOG2  (GRID_LOG2_MAX),
        .MAX_HEIGHT_LOG2 (GRID_LOG2_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // size register as the block sees it: 0 acts as 1, above the maximum saturates
    function automatic int unsigned used_log2(logic [lifet_pkg::LOG2_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > GRID_LOG2_MAX)
            return GRID_LOG2_MAX;
        return v;
    endfunction

    // applies one command to the shadow grid, returns the alive bit of its result
    function automatic logic apply_to_grid(logic [lifet_pkg::MODE_W-1:0] mode,
                                           logic [lifet_pkg::COORD_W-1:0] column,
                                           logic [lifet_pkg::COORD_W-1:0] row);
        int unsigned w;
        int unsigned h;
        int unsigned nr;
        int unsigned nc;
        int unsigned neighbors;
        logic [63:0] prev_cells [64];
        logic [lifet_pkg::COORD_W-1:0] cm;
        logic [lifet_pkg::COORD_W-1:0] rm;
        logic alive;
        w = 1 << used_log2(width_sel);
        h = 1 << used_log2(height_sel);
        cm = column & lifet_pkg::COORD_W'(w - 1);
        rm = row & lifet_pkg::COORD_W'(h - 1);
        alive = 1'b0;
        case (mode)
            lifet_pkg::MODE_CLEAR:
            begin
                foreach (shadow_cells[i])
                    shadow_cells[i] = '0;
            end
            lifet_pkg::MODE_SET:
                shadow_cells[rm][cm] = 1'b1;
            lifet_pkg::MODE_STEP:
            begin
                prev_cells = shadow_cells;
                foreach (shadow_cells[i])
                    shadow_cells[i] = '0;
                for (int unsigned r = 0; r < h; r++)
                begin
                    for (int unsigned c = 0; c < w; c++)
                    begin
                        neighbors = 0;
                        for (int unsigned dr = 0; dr < 3; dr++)
                        begin
                            for (int unsigned dc = 0; dc < 3; dc++)
                            begin
                                if (dr == 1 && dc == 1)
                                    continue;
                                nr = (r + dr + h - 1) & (h - 1);
                                nc = (c + dc + w - 1) & (w - 1);
                                neighbors += prev_cells[nr][nc];
                            end
                        end
                        if (neighbors == lifet_pkg::BIRTH_COUNT ||
                            (neighbors == lifet_pkg::SURVIVE_COUNT && prev_cells[r][c]))
                            shadow_cells[r][c] = 1'b1;
                    end
                end
            end
            default:
                alive = shadow_cells[rm][cm];
        endcase
        return alive;
    endfunction

    // coordinate near a window origin, wrapped to the active size, upper bits random; one pick in ten is fully random
    function automatic logic [lifet_pkg::COORD_W-1:0] pick_coord(
        logic [lifet_pkg::COORD_W-1:0] origin,
        logic [lifet_pkg::LOG2_W-1:0]  sel);
        logic [lifet_pkg::COORD_W-1:0] mask;
        logic [lifet_pkg::COORD_W-1:0] v;
        mask = lifet_pkg::COORD_W'((1 << used_log2(sel)) - 1);
        if ($urandom_range(0, 9) == 0)
            return lifet_pkg::COORD_W'($urandom);
        v = (origin + lifet_pkg::COORD_W'($urandom_range(0, 7))) & mask;
        return v | (lifet_pkg::COORD_W'($urandom) & ~mask);
    endfunction

    task automatic send_command(input logic [lifet_pkg::MODE_W-1:0] mode,
                                input logic [lifet_pkg::COORD_W-1:0] column,
                                input logic [lifet_pkg::COORD_W-1:0] row, input logic typed,
                                input logic typed_alive);
        int unsigned gap;
        logic predicted;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.mode   <= mode;
        cmd_ch.column <= column;
        cmd_ch.row    <= row;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        predicted = apply_to_grid(mode, column, row);
        alive_queue.push_back(typed ? typed_alive : predicted);
    endtask

    // lets every outstanding result arrive so the block is idle
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (alive_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size(input logic reg_idx, input logic [lifet_pkg::LOG2_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {(lifet_pkg::APB_DATA_W - lifet_pkg::LOG2_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == lifet_pkg::REG_WIDTH_LOG2)
            width_sel = value;
        else
            height_sel = value;
        @(posedge clk);
    endtask

    task automatic check_result(input logic alive);
        logic want;
        results_seen++;
        if (alive_queue.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with nothing expected, alive=%0b",
                         results_seen, alive);
        end
        else
        begin
            want = alive_queue.pop_front();
            if (alive !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected alive=%0b, got %0b",
                             results_seen, want, alive);
            end
        end
    endtask

    // result side: random stall before each beat while stalls are on
    initial
    begin
        int unsigned stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = stalls_on ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            check_result(res_ch.alive);
        end
    end

    initial
    begin
        logic [lifet_pkg::LOG2_W-1:0]  width_pick [6];
        logic [lifet_pkg::LOG2_W-1:0]  height_pick [6];
        logic [lifet_pkg::COORD_W-1:0] col_origin;
        logic [lifet_pkg::COORD_W-1:0] row_origin;
        logic [lifet_pkg::MODE_W-1:0]  mode;
        int unsigned pick;

        width_pick  = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd0, 3'd7};
        height_pick = '{3'd0, 3'd7, 3'd6, 3'd1, 3'd7, 3'd0};
        cmd_ch.valid  <= 1'b0;
        cmd_ch.mode   <= lifet_pkg::MODE_CLEAR;
        cmd_ch.column <= '0;
        cmd_ch.row    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        width_sel  = lifet_pkg::LOG2_RESET;
        height_sel = lifet_pkg::LOG2_RESET;
        foreach (shadow_cells[i])
            shadow_cells[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (directed_rows[i])
            send_command(directed_rows[i].mode, directed_rows[i].column, directed_rows[i].row,
                         directed_rows[i].typed, directed_rows[i].alive);

        // grid is kept across phases so cells outside a shrunk area can come back later unless a generation kills them
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            write_size(lifet_pkg::REG_WIDTH_LOG2,
                       phase < 6 ? width_pick[phase] : lifet_pkg::LOG2_W'($urandom));
            write_size(lifet_pkg::REG_HEIGHT_LOG2,
                       phase < 6 ? height_pick[phase] : lifet_pkg::LOG2_W'($urandom));
            gaps_on    = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : ($urandom_range(0, 2) != 0);
            stalls_on  = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : ($urandom_range(0, 2) != 0);
            col_origin = lifet_pkg::COORD_W'($urandom);
            row_origin = lifet_pkg::COORD_W'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    mode = lifet_pkg::MODE_CLEAR;
                else if (pick < 40)
                    mode = lifet_pkg::MODE_SET;
                else if (pick < 55)
                    mode = lifet_pkg::MODE_STEP;
                else
                    mode = lifet_pkg::MODE_READ;
                send_command(mode, pick_coord(col_origin, width_sel),
                             pick_coord(row_origin, height_sel), 1'b0, 1'b0);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && alive_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lifet_pkg.sv
hw/rtl/lifet_cmd_if.sv
hw/rtl/lifet_res_if.sv
hw/rtl/lifet_ram.sv
hw/rtl/lifet_cfg.sv
hw/rtl/lifet_row_unit.sv
hw/rtl/life_automaton_torus_grid.sv
test/life_automaton_torus_grid_test.sv
